// File: src/tfp_pkg.sv
// Shared package for the thermostat fan controller: event and register codes,
// fixed-point conversion constants, the pipeline payload types and lookup functions.
// No dependencies.
package tfp_pkg;

    localparam logic [1:0] REQ_TICK    = 2'd0;
    localparam logic [1:0] REQ_BUTTON  = 2'd1;
    localparam logic [1:0] REQ_DISPLAY = 2'd2;

    localparam logic [1:0] CFG_ID_LEFT    = 2'd0;
    localparam logic [1:0] CFG_ID_RIGHT   = 2'd1;
    localparam logic [1:0] CFG_HOLD_TICKS = 2'd2;

    localparam logic [1:0] DIG_NONE  = 2'd0;
    localparam logic [1:0] DIG_LEFT  = 2'd1;
    localparam logic [1:0] DIG_RIGHT = 2'd2;

    localparam logic [3:0] AVG_BATCH      = 4'd5;
    localparam logic [3:0] ID_LEFT_RST    = 4'd2;
    localparam logic [3:0] ID_RIGHT_RST   = 4'd3;
    localparam logic [3:0] HOLD_TICKS_RST = 4'd10;

    // Exact reciprocal multipliers: floor(x/5) and floor(x/102300).
    localparam logic [15:0] DIV5_RECIP  = 16'd52429;
    localparam logic [16:0] TEMP_GAIN   = 17'd65880;
    localparam logic signed [29:0] TEMP_OFFSET = 30'sd7296036;
    localparam logic [28:0] TEMP_RECIP  = 29'd343933257;
    localparam logic [7:0]  DIV10_RECIP = 8'd205;

    localparam logic signed [12:0] DUTY_LOW_F  = 13'sd76;
    localparam logic signed [12:0] DUTY_HIGH_F = 13'sd86;
    localparam logic [11:0] DUTY_MAX = 12'd3890;

    typedef struct packed {
        logic       update;
        logic [1:0] enable;
        logic       use_id;
        logic [7:0] id_segs;
        logic       hold;
    } ctl_t;

    typedef struct packed {
        ctl_t              ctl;
        logic signed [12:0] temp;
    } conv_t;

    function automatic logic [7:0] seg_lut(input logic [3:0] digit);
        logic [7:0] segs;
        begin
            case (digit)
                4'd0:    segs = 8'h3F;
                4'd1:    segs = 8'h06;
                4'd2:    segs = 8'h5B;
                4'd3:    segs = 8'h4F;
                4'd4:    segs = 8'h66;
                4'd5:    segs = 8'h6D;
                4'd6:    segs = 8'h7D;
                4'd7:    segs = 8'h07;
                4'd8:    segs = 8'h7F;
                4'd9:    segs = 8'h67;
                4'd10:   segs = 8'h01;
                4'd11:   segs = 8'h02;
                4'd12:   segs = 8'h04;
                4'd13:   segs = 8'h08;
                4'd14:   segs = 8'h10;
                default: segs = 8'h20;
            endcase
            return segs;
        end
    endfunction

    function automatic logic [11:0] duty_lut(input logic signed [12:0] temp);
        logic signed [12:0] offs;
        logic [11:0]        duty;
        begin
            offs = temp - DUTY_LOW_F;
            if (temp < DUTY_LOW_F)
            begin
                duty = 12'd0;
            end
            else if (temp > DUTY_HIGH_F)
            begin
                duty = DUTY_MAX;
            end
            else
            begin
                case (offs[3:0])
                    4'd0:    duty = 12'd409;
                    4'd1:    duty = 12'd1023;
                    4'd2:    duty = 12'd819;
                    4'd3:    duty = 12'd1228;
                    4'd4:    duty = 12'd1638;
                    4'd5:    duty = 12'd2047;
                    4'd6:    duty = 12'd2457;
                    4'd7:    duty = 12'd2866;
                    4'd8:    duty = 12'd3276;
                    4'd9:    duty = 12'd3685;
                    default: duty = DUTY_MAX;
                endcase
            end
            return duty;
        end
    endfunction

endpackage

// File: src/tfp_ctrl.sv
// Event control stage: configuration registers, tick counting, hold mode,
// sample accumulation and display alternation. Depends on tfp_pkg.
module tfp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_addr,
    input  logic [3:0]          cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          req_type,
    input  logic [9:0]          adc_sample,
    output logic                out_valid,
    input  logic                out_ready,
    output tfp_pkg::ctl_t       out_ctl,
    output logic [13:0]         out_sum
);

    logic [3:0]    id_left_reg;
    logic [3:0]    id_right_reg;
    logic [3:0]    hold_ticks_reg;
    logic [3:0]    tick_reg;
    logic [3:0]    tick_next;
    logic [13:0]   sum_reg;
    logic [13:0]   sum_next;
    logic          hold_reg;
    logic          hold_next;
    logic          have_reg;
    logic          have_next;
    logic          show_right_reg;
    logic          show_right_next;
    logic          valid_reg;
    tfp_pkg::ctl_t ctl_reg;
    tfp_pkg::ctl_t ctl_next;
    logic [13:0]   snap_reg;
    logic [13:0]   snap_next;
    logic [3:0]    tick_inc;
    logic [13:0]   sum_add;
    logic [3:0]    id_digit;
    logic          accept;

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_sum   = snap_reg;
    assign tick_inc  = tick_reg + 4'd1;
    assign sum_add   = sum_reg + {4'd0, adc_sample};

    always_comb
    begin
        tick_next       = tick_reg;
        sum_next        = sum_reg;
        hold_next       = hold_reg;
        have_next       = have_reg;
        show_right_next = show_right_reg;
        snap_next       = sum_add;
        id_digit        = id_left_reg;
        ctl_next        = '0;
        case (req_type)
            tfp_pkg::REQ_TICK:
            begin
                if (hold_reg)
                begin
                    if (tick_inc == hold_ticks_reg)
                    begin
                        hold_next = 1'b0;
                        tick_next = 4'd0;
                    end
                    else
                    begin
                        tick_next = tick_inc;
                    end
                end
                else if (tick_inc == tfp_pkg::AVG_BATCH)
                begin
                    ctl_next.update = 1'b1;
                    sum_next        = 14'd0;
                    tick_next       = 4'd0;
                    have_next       = 1'b1;
                end
                else
                begin
                    sum_next  = sum_add;
                    tick_next = tick_inc;
                end
            end
            tfp_pkg::REQ_BUTTON:
            begin
                hold_next = 1'b1;
            end
            tfp_pkg::REQ_DISPLAY:
            begin
                if (hold_reg || have_reg)
                begin
                    ctl_next.enable = show_right_reg ? tfp_pkg::DIG_RIGHT : tfp_pkg::DIG_LEFT;
                    ctl_next.use_id = hold_reg;
                    id_digit        = show_right_reg ? id_right_reg : id_left_reg;
                    show_right_next = !show_right_reg;
                end
            end
            default:
            begin
            end
        endcase
        ctl_next.id_segs = tfp_pkg::seg_lut(id_digit);
        ctl_next.hold    = hold_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_left_reg    <= tfp_pkg::ID_LEFT_RST;
            id_right_reg   <= tfp_pkg::ID_RIGHT_RST;
            hold_ticks_reg <= tfp_pkg::HOLD_TICKS_RST;
            tick_reg       <= 4'd0;
            sum_reg        <= 14'd0;
            hold_reg       <= 1'b0;
            have_reg       <= 1'b0;
            show_right_reg <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    tfp_pkg::CFG_ID_LEFT:    id_left_reg    <= cfg_wdata;
                    tfp_pkg::CFG_ID_RIGHT:   id_right_reg   <= cfg_wdata;
                    tfp_pkg::CFG_HOLD_TICKS: hold_ticks_reg <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
            if (accept)
            begin
                tick_reg       <= tick_next;
                sum_reg        <= sum_next;
                hold_reg       <= hold_next;
                have_reg       <= have_next;
                show_right_reg <= show_right_next;
            end
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctl_reg  <= ctl_next;
            snap_reg <= snap_next;
        end
    end

endmodule

// File: src/tfp_conv.sv
// Four-stage conversion pipeline from a five-sample sum to whole degrees
// Fahrenheit, carrying each item's control fields alongside. Depends on tfp_pkg.
module tfp_conv (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  tfp_pkg::ctl_t  in_ctl,
    input  logic [13:0]    in_sum,
    output logic           out_valid,
    input  logic           out_ready,
    output tfp_pkg::conv_t out_data
);

    localparam int STAGES = 4;

    logic [STAGES-1:0]  valid_reg;
    logic [STAGES-1:0]  stage_rdy;
    tfp_pkg::ctl_t      ctl_reg [STAGES];
    logic [11:0]        avg_reg;
    logic signed [29:0] num_reg;
    logic [56:0]        prod_reg;
    logic               neg_reg;
    logic signed [12:0] temp_reg;
    logic [29:0]        avg_prod;
    logic [28:0]        gain_prod;
    logic [27:0]        num_mag;
    logic [11:0]        quot;

    always_comb
    begin
        stage_rdy[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            stage_rdy[i] = !valid_reg[i] || stage_rdy[i+1];
        end
    end

    assign in_ready  = stage_rdy[0];
    assign out_valid = valid_reg[STAGES-1];
    assign out_data  = '{ctl: ctl_reg[STAGES-1], temp: temp_reg};

    assign avg_prod  = in_sum * tfp_pkg::DIV5_RECIP;
    assign gain_prod = avg_reg * tfp_pkg::TEMP_GAIN;
    assign num_mag   = num_reg[29] ? 28'(-num_reg) : num_reg[27:0];
    assign quot      = prod_reg[56:45];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_rdy[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < STAGES; i++)
            begin
                if (stage_rdy[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_rdy[0])
        begin
            ctl_reg[0] <= in_ctl;
            avg_reg    <= avg_prod[29:18];
        end
        if (stage_rdy[1])
        begin
            ctl_reg[1] <= ctl_reg[0];
            num_reg    <= $signed({1'b0, gain_prod}) - tfp_pkg::TEMP_OFFSET;
        end
        if (stage_rdy[2])
        begin
            ctl_reg[2] <= ctl_reg[1];
            prod_reg   <= num_mag * tfp_pkg::TEMP_RECIP;
            neg_reg    <= num_reg[29];
        end
        if (stage_rdy[3])
        begin
            ctl_reg[3] <= ctl_reg[2];
            temp_reg   <= neg_reg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
        end
    end

endmodule

// File: src/tfp_disp.sv
// Result stage: holds the stored reading, PWM compare and display digits,
// and forms the result register. Depends on tfp_pkg.
module tfp_disp (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  tfp_pkg::conv_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [39:0]    out_data
);

    logic [11:0] duty_reg;
    logic [11:0] temp_reg;
    logic [3:0]  tens_reg;
    logic [3:0]  ones_reg;
    logic        valid_reg;
    logic [39:0] data_reg;
    logic [6:0]  sat_temp;
    logic [14:0] tens_prod;
    logic [3:0]  tens_new;
    logic [6:0]  ones_full;
    logic [11:0] duty_cur;
    logic [11:0] temp_cur;
    logic [7:0]  segs;
    logic        load;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        if (in_data.temp < 13'sd0)
        begin
            sat_temp = 7'd0;
        end
        else if (in_data.temp > 13'sd99)
        begin
            sat_temp = 7'd99;
        end
        else
        begin
            sat_temp = in_data.temp[6:0];
        end
        tens_prod = sat_temp * tfp_pkg::DIV10_RECIP;
        tens_new  = tens_prod[14:11];
        ones_full = sat_temp - ({3'd0, tens_new} * 7'd10);
        duty_cur  = in_data.ctl.update ? tfp_pkg::duty_lut(in_data.temp) : duty_reg;
        temp_cur  = in_data.ctl.update ? in_data.temp[11:0] : temp_reg;
        if (in_data.ctl.enable == tfp_pkg::DIG_NONE)
        begin
            segs = 8'd0;
        end
        else if (in_data.ctl.use_id)
        begin
            segs = in_data.ctl.id_segs;
        end
        else
        begin
            segs = tfp_pkg::seg_lut((in_data.ctl.enable == tfp_pkg::DIG_LEFT) ?
                                    tens_reg : ones_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg  <= 12'd0;
            temp_reg  <= 12'd0;
            tens_reg  <= 4'd0;
            ones_reg  <= 4'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load && in_data.ctl.update)
            begin
                duty_reg <= duty_cur;
                temp_reg <= temp_cur;
                tens_reg <= tens_new;
                ones_reg <= ones_full[3:0];
            end
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= {4'd0, in_data.ctl.hold, segs, in_data.ctl.enable,
                         temp_cur, duty_cur, in_data.ctl.update};
        end
    end

endmodule

// File: src/thermostat_fan_pwm_with_display.sv
// Top level of the thermostat fan controller with two-digit display.
// Depends on tfp_pkg, tfp_ctrl, tfp_conv and tfp_disp.
//
// Each input item is an event: s_tuser gives its kind (second tick with a
// sample in s_tdata, button press or display tick). Every input item gives
// exactly one result item on the master side, in order, carrying the PWM
// compare, the last Fahrenheit reading, the display strobe and segments and
// the hold flag. The three configuration registers (left ID digit, right ID
// digit, hold length in ticks) are written through cfg_we, cfg_addr and
// cfg_wdata; the user must write them only while no item is in flight, as
// the block does not enforce this. An item enters the control stage when
// accepted, passes four conversion stages and is shown in the result
// register. One item is accepted every cycle unless m_tready stalls a full
// pipeline; each stage has its own valid bit, so the input keeps being
// accepted while a result waits, until the pipeline is full. When m_tready is
// low the results are held unchanged; s_tready falls once all stages are full.
// Reset clears all counters, the sum, the stored reading and the pipeline,
// and loads the registers with ID digits 2 and 3 and a hold of 10 ticks.
module thermostat_fan_pwm_with_display (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // adc_sample[9:0], zero padding
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // duty_update, duty_compare[11:0], temp_f[11:0],
                                   // digit_enable[1:0], segments[7:0], hold_active,
                                   // zero padding
);

    logic           ctrl_valid;
    logic           ctrl_ready;
    tfp_pkg::ctl_t  ctrl_ctl;
    logic [13:0]    ctrl_sum;
    logic           conv_valid;
    logic           conv_ready;
    tfp_pkg::conv_t conv_data;

    tfp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .req_type   (s_tuser),
        .adc_sample (s_tdata[9:0]),
        .out_valid  (ctrl_valid),
        .out_ready  (ctrl_ready),
        .out_ctl    (ctrl_ctl),
        .out_sum    (ctrl_sum)
    );

    tfp_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ctrl_valid),
        .in_ready  (ctrl_ready),
        .in_ctl    (ctrl_ctl),
        .in_sum    (ctrl_sum),
        .out_valid (conv_valid),
        .out_ready (conv_ready),
        .out_data  (conv_data)
    );

    tfp_disp u_disp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (conv_valid),
        .in_ready  (conv_ready),
        .in_data   (conv_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

// File: tb/tfp_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the thermostat fan controller testbench: a cycle-free predictor
// of every result item and the queue of results still awaited.
// Depends on tfp_pkg for the event, register and display codes.
package tfp_tb_pkg;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam longint TEMP_SCALE  = 65880;
    localparam longint TEMP_SHIFT  = 7296036;
    localparam longint TEMP_DIVIDE = 102300;
    localparam longint FAN_ON_F    = 76;
    localparam longint FAN_FULL_F  = 86;

    localparam logic [16*8-1:0] SEG_CODES = {
        8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 8'h01, 8'h67, 8'h7F,
        8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
    };

    localparam logic [11*12-1:0] DUTY_CODES = {
        12'd3890, 12'd3685, 12'd3276, 12'd2866, 12'd2457, 12'd2047,
        12'd1638, 12'd1228, 12'd819, 12'd1023, 12'd409
    };

    typedef struct packed {
        logic        update;
        logic [11:0] duty;
        logic [11:0] temp;
        logic [1:0]  enable;
        logic [7:0]  segs;
        logic        hold;
    } fan_result_t;

    class fan_scoreboard;
        logic [3:0]  id_left;
        logic [3:0]  id_right;
        logic [3:0]  hold_len;
        logic [3:0]  ticks;
        logic [13:0] sum;
        logic        holding;
        logic        have_reading;
        logic        show_right;
        logic [3:0]  tens;
        logic [3:0]  ones;
        logic [11:0] duty;
        logic [11:0] temp;
        fan_result_t awaited_q[$];
        int          mismatches;
        int          results_seen;

        function new();
            id_left      = tfp_pkg::ID_LEFT_RST;
            id_right     = tfp_pkg::ID_RIGHT_RST;
            hold_len     = tfp_pkg::HOLD_TICKS_RST;
            ticks        = '0;
            sum          = '0;
            holding      = 1'b0;
            have_reading = 1'b0;
            show_right   = 1'b0;
            tens         = '0;
            ones         = '0;
            duty         = '0;
            temp         = '0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction

        function void write_reg(logic [1:0] idx, logic [3:0] val);
            case (idx)
                tfp_pkg::CFG_ID_LEFT:    id_left = val;
                tfp_pkg::CFG_ID_RIGHT:   id_right = val;
                tfp_pkg::CFG_HOLD_TICKS: hold_len = val;
                default:                 ;
            endcase
        endfunction

        function void average_reading();
            longint avg;
            longint f;
            longint d;
            avg = longint'(sum) / 5;
            f = (avg * TEMP_SCALE - TEMP_SHIFT) / TEMP_DIVIDE;
            if (f < FAN_ON_F)
                duty = '0;
            else if (f > FAN_FULL_F)
                duty = tfp_pkg::DUTY_MAX;
            else
                duty = DUTY_CODES[(f - FAN_ON_F) * 12 +: 12];
            temp = f[11:0];
            if (f < 0)
                d = 0;
            else if (f > 99)
                d = 99;
            else
                d = f;
            tens = 4'(d / 10);
            ones = 4'(d % 10);
            have_reading = 1'b1;
            sum = '0;
        endfunction

        function void note_input(logic [1:0] req, logic [9:0] smp);
            fan_result_t r;
            logic [3:0]  digit;
            r = '0;
            case (req)
                tfp_pkg::REQ_TICK:
                begin
                    ticks = ticks + 4'd1;
                    if (holding)
                    begin
                        if (ticks == hold_len)
                        begin
                            holding = 1'b0;
                            ticks = '0;
                        end
                    end
                    else
                    begin
                        sum = sum + 14'(smp);
                        if (ticks == tfp_pkg::AVG_BATCH)
                        begin
                            average_reading();
                            ticks = '0;
                            r.update = 1'b1;
                        end
                    end
                end
                tfp_pkg::REQ_BUTTON:
                    holding = 1'b1;
                tfp_pkg::REQ_DISPLAY:
                begin
                    if (holding || have_reading)
                    begin
                        if (show_right)
                        begin
                            digit = holding ? id_right : ones;
                            r.enable = tfp_pkg::DIG_RIGHT;
                        end
                        else
                        begin
                            digit = holding ? id_left : tens;
                            r.enable = tfp_pkg::DIG_LEFT;
                        end
                        r.segs = SEG_CODES[digit * 8 +: 8];
                        show_right = !show_right;
                    end
                end
                default:
                    ;
            endcase
            r.duty = duty;
            r.temp = temp;
            r.hold = holding;
            awaited_q.push_back(r);
        endfunction

        function void check_result(logic [39:0] data);
            fan_result_t got;
            fan_result_t want;
            got.update = data[0];
            got.duty   = data[12:1];
            got.temp   = data[24:13];
            got.enable = data[26:25];
            got.segs   = data[34:27];
            got.hold   = data[35];
            results_seen++;
            if (awaited_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("result %0d arrived with nothing awaited: %h", results_seen, data);
                mismatches++;
                return;
            end
            want = awaited_q.pop_front();
            if (got !== want)
            begin
                if (mismatches < 10)
                    $display({"result %0d: expected upd=%0d duty=%0d temp=%0d dig=%0d seg=%h ",
                              "hold=%0d, got upd=%0d duty=%0d temp=%0d dig=%0d seg=%h hold=%0d"},
                             results_seen, want.update, want.duty, want.temp, want.enable,
                             want.segs, want.hold, got.update, got.duty, got.temp, got.enable,
                             got.segs, got.hold);
                mismatches++;
            end
        endfunction
    endclass

endpackage

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Top level of the thermostat fan controller testbench: drives events and
// register writes, stalls both stream sides at random and checks every result.
// Depends on tfp_pkg, tfp_tb_pkg and thermostat_fan_pwm_with_display.
module tb_top;

    localparam int ITEMS_PER_PHASE = 180;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int STALL_CYCLES    = 60;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [3:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    tfp_tb_pkg::fan_scoreboard sb;
    int src_idle = 27;
    int snk_idle = 58;
    int stall_starts = 0;
    int stall_seen = 0;
    int stall_left = 0;
    int cycle_count = 0;

    thermostat_fan_pwm_with_display DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (s_tvalid && s_tready)
                sb.note_input(s_tuser, s_tdata[9:0]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    always @(posedge clk)
    begin
        if (stall_starts != stall_seen)
        begin
            stall_seen = stall_starts;
            stall_left = STALL_CYCLES;
        end
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= snk_idle);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("thermostat_fan_pwm_with_display: mismatch");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] req, input logic [9:0] smp);
        while ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {6'd0, smp};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_random_item();
        int         pick;
        logic [1:0] req;
        logic [9:0] smp;
        pick = $urandom_range(99);
        if (pick < 60)
            req = tfp_pkg::REQ_TICK;
        else if (pick < 88)
            req = tfp_pkg::REQ_DISPLAY;
        else if (pick < 96)
            req = tfp_pkg::REQ_BUTTON;
        else
            req = tfp_tb_pkg::REQ_UNUSED;
        if ($urandom_range(1) != 0)
            smp = 10'($urandom_range(255, 215));
        else
            smp = 10'($urandom);
        send_item(req, smp);
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic apply_settings(input logic [3:0] left, input logic [3:0] right,
                                  input logic [3:0] hold);
        write_reg(tfp_pkg::CFG_ID_LEFT, left);
        write_reg(tfp_pkg::CFG_ID_RIGHT, right);
        write_reg(tfp_pkg::CFG_HOLD_TICKS, hold);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        sb = new();
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(tfp_pkg::REQ_DISPLAY, 10'd0);
        send_item(tfp_tb_pkg::REQ_UNUSED, 10'h3FF);
        repeat (5) send_item(tfp_pkg::REQ_TICK, 10'h3FF);
        repeat (2) send_item(tfp_pkg::REQ_DISPLAY, 10'd0);
        repeat (5) send_item(tfp_pkg::REQ_TICK, 10'd0);
        send_item(tfp_pkg::REQ_DISPLAY, 10'd0);
        repeat (5) send_item(tfp_pkg::REQ_TICK, 10'd229);
        send_item(tfp_pkg::REQ_BUTTON, 10'd0);
        send_item(tfp_pkg::REQ_BUTTON, 10'h3FF);
        repeat (2) send_item(tfp_pkg::REQ_DISPLAY, 10'd0);
        send_item(tfp_pkg::REQ_TICK, 10'h2AA);
        wait_for_drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            src_idle = (phase < 2) ? 27 : ((phase < 4) ? 58 : 0);
            snk_idle = (phase < 2) ? 58 : ((phase < 4) ? 27 : 0);
            case (phase)
                0:       apply_settings(4'd0, 4'd9, 4'd1);
                1:       apply_settings(4'd9, 4'd0, 4'd15);
                2:       apply_settings(4'd15, 4'd10, 4'd0);
                3:       apply_settings(4'($urandom), 4'($urandom), 4'($urandom));
                4:       apply_settings(4'($urandom), 4'($urandom), 4'd5);
                default: apply_settings(tfp_pkg::ID_LEFT_RST, tfp_pkg::ID_RIGHT_RST,
                                        tfp_pkg::HOLD_TICKS_RST);
            endcase
            if (phase == 4)
                stall_starts++;
            repeat (ITEMS_PER_PHASE) send_random_item();
            wait_for_drain();
        end

        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("thermostat_fan_pwm_with_display: match");
        else
            $display("thermostat_fan_pwm_with_display: mismatch");
        $finish;
    end

endmodule
